// ===== hdl/pcf_pkg.sv =====
// Package for the pitch complementary filter.
// Holds the register map, command/status structs, state codes and helpers.
// No dependencies; every other file but pcf_if refers to it by scoped names.
package pcf_pkg;

    localparam int unsigned IDX_W = 5;   // CORDIC step index, covers up to 32 steps
    localparam int unsigned CX_W  = 34;  // CORDIC x and y
    localparam int unsigned ANG_W = 33;  // angle accumulator, Q3.28 with headroom
    localparam int unsigned MA_W  = 34;  // multiplier magnitude operand
    localparam int unsigned MB_W  = 17;  // multiplier coefficient operand
    localparam int unsigned MP_W  = MA_W + MB_W;
    localparam int unsigned ACC_W = 67;  // product accumulator
    localparam int unsigned SUM_W = 48;  // saturating sums

    localparam logic signed [ANG_W-1:0] Q28_PI = 33'sd843314857;
    localparam logic [16:0] W_ONE = 17'h10000;

    typedef enum logic [2:0] {
        CFG_GYRO_SCALE,
        CFG_ACCEL_X_OFFSET,
        CFG_BLEND_WEIGHT,
        CFG_BIAS_GAIN,
        CFG_RAMP_LOWER,
        CFG_RAMP_UPPER,
        CFG_RAMP_ENABLE
    } t_cfg_idx;

    typedef struct packed {
        logic [31:0]        gyro_scale;
        logic signed [15:0] accel_x_offset;
        logic [16:0]        blend_weight;
        logic [31:0]        bias_gain;
        logic signed [31:0] ramp_lower;
        logic signed [31:0] ramp_upper;
        logic               ramp_enable;
    } t_cfg;

    typedef enum logic [2:0] {
        MS_PRED_LO,
        MS_PRED_HI,
        MS_BLEND_P,
        MS_BLEND_O,
        MS_BIAS_LO,
        MS_BIAS_HI
    } t_mul_sel;

    typedef struct packed {
        logic             load;
        logic             cord_step;
        logic [IDX_W-1:0] cord_idx;
        logic             mul_en;
        logic             acc_clr;
        t_mul_sel         mul_sel;
        logic             pred_ld;
        logic             pitch_ld;
        logic             fin;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_sts;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CORD,
        ST_PM_LO,
        ST_PM_HI,
        ST_PRED,
        ST_BM_P,
        ST_BM_O,
        ST_BLEND,
        ST_GM_LO,
        ST_GM_HI,
        ST_FIN
    } t_state;

    // arctan(2^-i) in Q3.28
    function automatic logic [ANG_W-1:0] atan_step(input logic [IDX_W-1:0] i);
        logic [ANG_W-1:0] v;
        case (i)
            5'd0: v = 33'd210828714;
            5'd1: v = 33'd124459457;
            5'd2: v = 33'd65760959;
            5'd3: v = 33'd33381290;
            5'd4: v = 33'd16755422;
            5'd5: v = 33'd8385879;
            5'd6: v = 33'd4193963;
            5'd7: v = 33'd2097109;
            5'd8: v = 33'd1048571;
            5'd9: v = 33'd524287;
            default: begin
                if (i <= 5'd28) v = 33'd1 << (5'd28 - i);
                else v = '0;
            end
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [31:0] r;
        if (v > 48'sd2147483647) r = 32'sh7FFFFFFF;
        else if (v < -48'sd2147483648) r = 32'sh80000000;
        else r = v[31:0];
        return r;
    endfunction

endpackage

// ===== hdl/pcf_if.sv =====
// Channel interfaces of the pitch complementary filter: sample, result, config.
// Depends on nothing; payload widths follow the field list.
interface pcf_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] gyro_rate;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_z;
    modport source (output valid, gyro_rate, accel_x, accel_z, input ready);
    modport sink   (input valid, gyro_rate, accel_x, accel_z, output ready);
endinterface

interface pcf_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pitch_angle;
    logic               on_ramp;
    logic signed [31:0] gyro_bias;
    modport source (output valid, pitch_angle, on_ramp, gyro_bias, input ready);
    modport sink   (input valid, pitch_angle, on_ramp, gyro_bias, output ready);
endinterface

interface pcf_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/pcf_ctrl.sv =====
// Sequencer of the pitch complementary filter.
// Depends on pcf_pkg; drives the datapath by t_cmd and watches t_sts.
module pcf_ctrl #(
    parameter int CORDIC_ITERATIONS = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  pcf_pkg::t_sts i_sts,
    output pcf_pkg::t_cmd o_cmd
);

    localparam int ITW = $clog2(CORDIC_ITERATIONS);
    localparam logic [ITW-1:0] LAST = ITW'(CORDIC_ITERATIONS - 1);

    pcf_pkg::t_state r_state, n_state;
    logic [ITW-1:0]  r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcf_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            pcf_pkg::ST_IDLE: begin
                n_cnt = '0;
                if (i_in_valid) n_state = pcf_pkg::ST_CORD;
            end
            pcf_pkg::ST_CORD: begin
                if (r_cnt == LAST) n_state = pcf_pkg::ST_PM_LO;
                else n_cnt = r_cnt + 1'b1;
            end
            pcf_pkg::ST_PM_LO: n_state = pcf_pkg::ST_PM_HI;
            pcf_pkg::ST_PM_HI: n_state = pcf_pkg::ST_PRED;
            pcf_pkg::ST_PRED:  n_state = pcf_pkg::ST_BM_P;
            pcf_pkg::ST_BM_P:  n_state = pcf_pkg::ST_BM_O;
            pcf_pkg::ST_BM_O:  n_state = pcf_pkg::ST_BLEND;
            pcf_pkg::ST_BLEND: n_state = pcf_pkg::ST_GM_LO;
            pcf_pkg::ST_GM_LO: n_state = pcf_pkg::ST_GM_HI;
            pcf_pkg::ST_GM_HI: n_state = pcf_pkg::ST_FIN;
            pcf_pkg::ST_FIN: begin
                if (!i_sts.out_busy) n_state = pcf_pkg::ST_IDLE;
            end
            default: n_state = pcf_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd          = '0;
        o_cmd.mul_sel  = pcf_pkg::MS_PRED_LO;
        o_cmd.cord_idx = pcf_pkg::IDX_W'(r_cnt);
        o_in_ready     = 1'b0;
        case (r_state)
            pcf_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            pcf_pkg::ST_CORD: o_cmd.cord_step = 1'b1;
            pcf_pkg::ST_PM_LO: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.acc_clr = 1'b1;
                o_cmd.mul_sel = pcf_pkg::MS_PRED_LO;
            end
            pcf_pkg::ST_PM_HI: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = pcf_pkg::MS_PRED_HI;
            end
            pcf_pkg::ST_PRED: o_cmd.pred_ld = 1'b1;
            pcf_pkg::ST_BM_P: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.acc_clr = 1'b1;
                o_cmd.mul_sel = pcf_pkg::MS_BLEND_P;
            end
            pcf_pkg::ST_BM_O: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = pcf_pkg::MS_BLEND_O;
            end
            pcf_pkg::ST_BLEND: o_cmd.pitch_ld = 1'b1;
            pcf_pkg::ST_GM_LO: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.acc_clr = 1'b1;
                o_cmd.mul_sel = pcf_pkg::MS_BIAS_LO;
            end
            pcf_pkg::ST_GM_HI: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = pcf_pkg::MS_BIAS_HI;
            end
            pcf_pkg::ST_FIN: o_cmd.fin = !i_sts.out_busy;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== hdl/pcf_dp.sv =====
// Datapath of the pitch complementary filter: CORDIC, shared multiplier,
// filter state and result register. Depends on pcf_pkg; driven by pcf_ctrl.
module pcf_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pcf_pkg::t_cmd      i_cmd,
    input  pcf_pkg::t_cfg      i_cfg,
    input  logic signed [15:0] i_gyro_rate,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_z,
    output pcf_pkg::t_sts      o_sts,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_pitch_angle,
    output logic               o_on_ramp,
    output logic signed [31:0] o_gyro_bias
);

    localparam int unsigned CX_W  = pcf_pkg::CX_W;
    localparam int unsigned ANG_W = pcf_pkg::ANG_W;
    localparam int unsigned MA_W  = pcf_pkg::MA_W;
    localparam int unsigned MB_W  = pcf_pkg::MB_W;
    localparam int unsigned MP_W  = pcf_pkg::MP_W;
    localparam int unsigned ACC_W = pcf_pkg::ACC_W;
    localparam int unsigned SUM_W = pcf_pkg::SUM_W;
    localparam int unsigned RND_W = ACC_W - 28;

    logic signed [CX_W-1:0]  r_x, r_y;
    logic signed [ANG_W-1:0] r_z;
    logic                    r_zero;
    logic signed [33:0]      r_diff;
    logic signed [31:0]      r_pred;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [31:0]      r_pitch, r_bias;
    logic                    r_flag;
    logic                    r_out_valid;
    logic signed [31:0]      r_out_pitch, r_out_bias;
    logic                    r_out_flag;

    // sample load
    logic signed [16:0]     w_y17;
    logic signed [CX_W-1:0] w_x0, w_y0;
    assign w_y17 = 17'(i_accel_x) - 17'(i_cfg.accel_x_offset);
    assign w_x0  = CX_W'(i_accel_z) <<< 14;
    assign w_y0  = CX_W'(w_y17) <<< 14;

    // one CORDIC rotation
    logic signed [CX_W-1:0]  w_xs, w_ys;
    logic signed [ANG_W-1:0] w_at;
    assign w_xs = r_x >>> i_cmd.cord_idx;
    assign w_ys = r_y >>> i_cmd.cord_idx;
    assign w_at = signed'(pcf_pkg::atan_step(i_cmd.cord_idx));

    logic signed [ANG_W-1:0] w_obs;
    assign w_obs = r_zero ? '0 : r_z;

    // shared multiplier operands
    logic [16:0]        w_w, w_wc;
    logic signed [33:0] w_pred34, w_obs34, w_err;
    assign w_w      = (i_cfg.blend_weight > pcf_pkg::W_ONE) ? pcf_pkg::W_ONE
                                                            : i_cfg.blend_weight;
    assign w_wc     = pcf_pkg::W_ONE - w_w;
    assign w_pred34 = 34'(r_pred);
    assign w_obs34  = 34'(w_obs);
    assign w_err    = w_pred34 - w_obs34;

    logic [MA_W-1:0] w_diff_mag, w_pred_mag, w_obs_mag, w_err_mag;
    assign w_diff_mag = r_diff[33]   ? MA_W'(-r_diff)   : MA_W'(r_diff);
    assign w_pred_mag = w_pred34[33] ? MA_W'(-w_pred34) : MA_W'(w_pred34);
    assign w_obs_mag  = w_obs34[33]  ? MA_W'(-w_obs34)  : MA_W'(w_obs34);
    assign w_err_mag  = w_err[33]    ? MA_W'(-w_err)    : MA_W'(w_err);

    logic [MA_W-1:0] w_ma;
    logic [MB_W-1:0] w_mb;
    logic            w_hi, w_neg;
    always_comb begin
        w_ma  = w_diff_mag;
        w_mb  = {1'b0, i_cfg.gyro_scale[15:0]};
        w_hi  = 1'b0;
        w_neg = 1'b0;
        case (i_cmd.mul_sel)
            pcf_pkg::MS_PRED_LO: ;
            pcf_pkg::MS_PRED_HI: begin
                w_mb = {1'b0, i_cfg.gyro_scale[31:16]};
                w_hi = 1'b1;
            end
            pcf_pkg::MS_BLEND_P: begin
                w_ma  = w_pred_mag;
                w_mb  = w_w;
                w_neg = w_pred34[33];
            end
            pcf_pkg::MS_BLEND_O: begin
                w_ma  = w_obs_mag;
                w_mb  = w_wc;
                w_neg = w_obs34[33];
            end
            pcf_pkg::MS_BIAS_LO: begin
                w_ma = w_err_mag;
                w_mb = {1'b0, i_cfg.bias_gain[15:0]};
            end
            pcf_pkg::MS_BIAS_HI: begin
                w_ma = w_err_mag;
                w_mb = {1'b0, i_cfg.bias_gain[31:16]};
                w_hi = 1'b1;
            end
            default: ;
        endcase
    end

    logic [MP_W-1:0]         w_prod;
    logic signed [ACC_W-1:0] w_term, w_acc_base;
    assign w_prod     = MP_W'(w_ma) * MP_W'(w_mb);
    assign w_term     = signed'(ACC_W'(w_prod) << (w_hi ? 16 : 0));
    assign w_acc_base = i_cmd.acc_clr ? '0 : r_acc;

    // accumulator holds a magnitude product: round to Q28 and restore the sign
    logic [ACC_W-1:0]        w_rnd;
    logic [RND_W-1:0]        w_mag;
    logic signed [SUM_W-1:0] w_mag_s, w_delta_pred, w_delta_bias;
    assign w_rnd        = r_acc + (ACC_W'(1) << 27);
    assign w_mag        = w_rnd[ACC_W-1:28];
    assign w_mag_s      = signed'(SUM_W'(w_mag));
    assign w_delta_pred = r_diff[33] ? -w_mag_s : w_mag_s;
    assign w_delta_bias = w_err[33]  ? -w_mag_s : w_mag_s;

    logic signed [31:0]      w_pred_new, w_bias_new, w_pitch_new;
    logic signed [ACC_W-1:0] w_blend;
    assign w_pred_new  = pcf_pkg::sat32(SUM_W'(r_pitch) + w_delta_pred);
    assign w_bias_new  = pcf_pkg::sat32(SUM_W'(r_bias) + w_delta_bias);
    assign w_blend     = (r_acc + ACC_W'(32768)) >>> 16;
    assign w_pitch_new = pcf_pkg::sat32(w_blend[SUM_W-1:0]);

    logic w_flag_new;
    always_comb begin
        w_flag_new = r_flag;
        if (i_cfg.ramp_enable) begin
            if (r_flag) begin
                if (r_pitch < i_cfg.ramp_lower) w_flag_new = 1'b0;
            end else begin
                if (r_pitch > i_cfg.ramp_upper) w_flag_new = 1'b1;
            end
        end
    end

    // CORDIC, product, prediction and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_zero <= (w_y17 == '0) && (i_accel_z == '0);
            r_diff <= (34'(i_gyro_rate) <<< 16) - 34'(r_bias);
            if (i_accel_z < 0) begin
                r_x <= -w_x0;
                r_y <= -w_y0;
                r_z <= (w_y17 >= 0) ? pcf_pkg::Q28_PI : -pcf_pkg::Q28_PI;
            end else begin
                r_x <= w_x0;
                r_y <= w_y0;
                r_z <= '0;
            end
        end else if (i_cmd.cord_step) begin
            if (r_y > 0) begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_at;
            end else begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_at;
            end
        end
        if (i_cmd.mul_en) r_acc <= w_neg ? w_acc_base - w_term : w_acc_base + w_term;
        if (i_cmd.pred_ld) r_pred <= w_pred_new;
        if (i_cmd.fin) begin
            r_out_pitch <= r_pitch;
            r_out_bias  <= w_bias_new;
            r_out_flag  <= w_flag_new;
        end
    end

    // filter state and result handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch     <= '0;
            r_bias      <= '0;
            r_flag      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.pitch_ld) r_pitch <= w_pitch_new;
            if (i_cmd.fin) begin
                r_bias      <= w_bias_new;
                r_flag      <= w_flag_new;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_busy = r_out_valid && !i_ready;
    assign o_valid        = r_out_valid;
    assign o_pitch_angle  = r_out_pitch;
    assign o_on_ramp      = r_out_flag;
    assign o_gyro_bias    = r_out_bias;

endmodule

// ===== hdl/pitch_complementary_filter_top.sv =====
// Top level of the pitch complementary filter: register file and wiring.
// Depends on pcf_pkg, the pcf_*_if interfaces, pcf_ctrl and pcf_dp.
//
//   port       dir  payload                              beat when
//   i_sample   in   gyro_rate, accel_x, accel_z          valid && ready
//   o_result   out  pitch_angle, on_ramp, gyro_bias      valid && ready
//   i_cfg      in   index (3 b), data (32 b)             valid && ready
//
// Each sample runs the CORDIC rotations followed by six passes of the shared
// 34x17 multiplier. Samples are taken one at a time; the result sits in an
// output register. A stalled result holds the last step until it is taken.
// Reset clears pitch, bias and flag and loads the register defaults;
// the config channel never stalls.
module pitch_complementary_filter_top #(
    parameter int CORDIC_ITERATIONS = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pcf_sample_if.sink    i_sample,
    pcf_result_if.source  o_result,
    pcf_cfg_if.sink       i_cfg
);

    pcf_pkg::t_cfg r_cfg;
    pcf_pkg::t_cmd w_cmd;
    pcf_pkg::t_sts w_sts;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gyro_scale     <= '0;
            r_cfg.accel_x_offset <= '0;
            r_cfg.blend_weight   <= 17'd62259;
            r_cfg.bias_gain      <= '0;
            r_cfg.ramp_lower     <= 32'sd26843546;
            r_cfg.ramp_upper     <= 32'sd53687091;
            r_cfg.ramp_enable    <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                pcf_pkg::CFG_GYRO_SCALE:     r_cfg.gyro_scale     <= i_cfg.data;
                pcf_pkg::CFG_ACCEL_X_OFFSET: r_cfg.accel_x_offset <= i_cfg.data[15:0];
                pcf_pkg::CFG_BLEND_WEIGHT:   r_cfg.blend_weight   <= i_cfg.data[16:0];
                pcf_pkg::CFG_BIAS_GAIN:      r_cfg.bias_gain      <= i_cfg.data;
                pcf_pkg::CFG_RAMP_LOWER:     r_cfg.ramp_lower     <= i_cfg.data;
                pcf_pkg::CFG_RAMP_UPPER:     r_cfg.ramp_upper     <= i_cfg.data;
                pcf_pkg::CFG_RAMP_ENABLE:    r_cfg.ramp_enable    <= i_cfg.data[0];
                default: ;  // drop writes to unmapped indexes
            endcase
        end
    end

    pcf_ctrl #(
        .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample.valid),
        .o_in_ready (i_sample.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    pcf_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_cfg         (r_cfg),
        .i_gyro_rate   (i_sample.gyro_rate),
        .i_accel_x     (i_sample.accel_x),
        .i_accel_z     (i_sample.accel_z),
        .o_sts         (w_sts),
        .o_valid       (o_result.valid),
        .i_ready       (o_result.ready),
        .o_pitch_angle (o_result.pitch_angle),
        .o_on_ramp     (o_result.on_ramp),
        .o_gyro_bias   (o_result.gyro_bias)
    );

endmodule

// ===== verif/tb.sv =====
// Testbench for pitch_complementary_filter_top: directed and random IMU samples.
// Predicts pitch, ramp flag and gyro bias per beat and checks each result beat.
// Depends on pcf_pkg, the pcf_*_if interfaces and the filter RTL.
`timescale 1ns / 100ps

module tb;

    typedef struct {
        logic signed [15:0] gyro_rate;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_z;
    } t_imu_sample;

    typedef struct {
        logic signed [31:0] pitch_angle;
        logic               on_ramp;
        logic signed [31:0] gyro_bias;
    } t_filter_out;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    bit   rst_done = 0;
    bit   quiet = 0;
    bit   smp_taken = 0;
    int   tx_gap = 0;
    int   rx_gap = 0;
    int   hold_cnt = 0;
    int   errors = 0;

    t_imu_sample sample_q[$];
    t_filter_out pending_results[$];

    // filter state and register copies
    longint      est_pitch, est_bias;
    logic        est_flag;
    logic [31:0] r_scale, r_gain;
    longint      r_offset, r_lower, r_upper;
    logic [16:0] r_weight;
    logic        r_enable;

    const longint atan_tab[10] = '{210828714, 124459457, 65760959, 33381290, 16755422,
                                   8385879, 4193963, 2097109, 1048571, 524287};

    pcf_sample_if smp();
    pcf_result_if res();
    pcf_cfg_if    cfg();

    pitch_complementary_filter_top uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (smp),
        .o_result (res),
        .i_cfg    (cfg)
    );

    always #1 i_clk = ~i_clk;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // a * b / 2^28, rounded half away from zero
    function automatic longint scale_q28(longint a, logic [31:0] b);
        longint unsigned mag, hi, lo, r;
        mag = (a < 0) ? -a : a;
        hi = mag * b[31:16];
        lo = mag * b[15:0];
        r = (hi + (lo >> 16) + 2048) >> 12;
        return (a < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint accel_angle(longint y, longint x);
        longint z, xs, ys, step;
        z = 0;
        if (x == 0 && y == 0) return 0;
        x = x * 16384;
        y = y * 16384;
        if (x < 0) begin
            z = (y >= 0) ? 843314857 : -843314857;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            step = (i < 10) ? atan_tab[i] : (longint'(1) << (28 - i));
            if (y > 0) begin
                x += ys; y -= xs; z += step;
            end else begin
                x -= ys; y += xs; z -= step;
            end
        end
        return z;
    endfunction

    function automatic t_filter_out filter_update(t_imu_sample s);
        longint w, pred, obs, mix;
        t_filter_out o;
        w = (r_weight > 17'd65536) ? 65536 : longint'(r_weight);
        pred = clamp32(est_pitch + scale_q28(longint'(s.gyro_rate) * 65536 - est_bias, r_scale));
        obs = accel_angle(longint'(s.accel_x) - r_offset, longint'(s.accel_z));
        mix = (w * pred + (65536 - w) * obs + 32768) >>> 16;
        est_pitch = clamp32(mix);
        est_bias = clamp32(est_bias + scale_q28(pred - obs, r_gain));
        if (r_enable) begin
            if (est_flag) begin
                if (est_pitch < r_lower) est_flag = 1'b0;
            end else if (est_pitch > r_upper) begin
                est_flag = 1'b1;
            end
        end
        o.pitch_angle = est_pitch[31:0];
        o.on_ramp = est_flag;
        o.gyro_bias = est_bias[31:0];
        return o;
    endfunction

    // check beats and record accepted samples
    always @(posedge i_clk) begin
        t_filter_out want;
        smp_taken = smp.valid && smp.ready && i_rst_n;
        if (smp_taken)
            pending_results.push_back(filter_update('{smp.gyro_rate, smp.accel_x, smp.accel_z}));
        if (i_rst_n && res.valid && res.ready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (res.pitch_angle !== want.pitch_angle) begin
                    $error("pitch_angle expected %0d actual %0d", want.pitch_angle,
                           res.pitch_angle);
                    errors++;
                end
                if (res.on_ramp !== want.on_ramp) begin
                    $error("on_ramp expected %0b actual %0b", want.on_ramp, res.on_ramp);
                    errors++;
                end
                if (res.gyro_bias !== want.gyro_bias) begin
                    $error("gyro_bias expected %0d actual %0d", want.gyro_bias,
                           res.gyro_bias);
                    errors++;
                end
            end
        end
    end

    // sample driver: advance only once the current beat is taken
    always @(negedge i_clk) begin
        t_imu_sample s;
        if (rst_done && (!smp.valid || smp_taken)) begin
            if (tx_gap > 0) begin
                smp.valid <= 1'b0;
                tx_gap--;
            end else if (sample_q.size() != 0) begin
                s = sample_q.pop_front();
                smp.gyro_rate <= s.gyro_rate;
                smp.accel_x <= s.accel_x;
                smp.accel_z <= s.accel_z;
                smp.valid <= 1'b1;
                if (!quiet && $urandom_range(0, 6) == 0) tx_gap = $urandom_range(1, 10);
            end else begin
                smp.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
    end

    always @(negedge i_clk) begin
        if (!rst_done || hold_cnt != 0) begin
            res.ready <= 1'b0;
        end else if (rx_gap > 0) begin
            res.ready <= 1'b0;
            rx_gap--;
        end else begin
            res.ready <= 1'b1;
            if (!quiet && $urandom_range(0, 6) == 0) rx_gap = $urandom_range(1, 10);
        end
    end

    task automatic write_reg(pcf_pkg::t_cfg_idx idx, logic [31:0] d);
        @(negedge i_clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= d;
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
        case (idx)
            pcf_pkg::CFG_GYRO_SCALE:     r_scale = d;
            pcf_pkg::CFG_ACCEL_X_OFFSET: r_offset = longint'($signed(d[15:0]));
            pcf_pkg::CFG_BLEND_WEIGHT:   r_weight = d[16:0];
            pcf_pkg::CFG_BIAS_GAIN:      r_gain = d;
            pcf_pkg::CFG_RAMP_LOWER:     r_lower = longint'($signed(d));
            pcf_pkg::CFG_RAMP_UPPER:     r_upper = longint'($signed(d));
            pcf_pkg::CFG_RAMP_ENABLE:    r_enable = d[0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic write_all(logic [31:0] scale, logic [15:0] offset, logic [16:0] weight,
                             logic [31:0] gain, logic [31:0] lower, logic [31:0] upper,
                             logic enable);
        write_reg(pcf_pkg::CFG_GYRO_SCALE, scale);
        write_reg(pcf_pkg::CFG_ACCEL_X_OFFSET, {16'h0, offset});
        write_reg(pcf_pkg::CFG_BLEND_WEIGHT, {15'h0, weight});
        write_reg(pcf_pkg::CFG_BIAS_GAIN, gain);
        write_reg(pcf_pkg::CFG_RAMP_LOWER, lower);
        write_reg(pcf_pkg::CFG_RAMP_UPPER, upper);
        write_reg(pcf_pkg::CFG_RAMP_ENABLE, {31'h0, enable});
    endtask

    // mostly plausible motion, the rest raw noise over the full field range
    task automatic add_random(int n);
        t_imu_sample s;
        repeat (n) begin
            if ($urandom_range(0, 3) == 0) begin
                s.gyro_rate = 16'($urandom);
                s.accel_x = 16'($urandom);
                s.accel_z = 16'($urandom);
            end else begin
                s.gyro_rate = $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
                s.accel_x = $signed(16'($urandom_range(0, 16000))) - 16'sd8000;
                s.accel_z = $signed(16'($urandom_range(8000, 16000)));
            end
            sample_q.push_back(s);
        end
    endtask

    task automatic drain();
        while (sample_q.size() != 0 || pending_results.size() != 0 || smp.valid)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    initial begin
        smp.valid = 1'b0;
        smp.gyro_rate = '0;
        smp.accel_x = '0;
        smp.accel_z = '0;
        res.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = pcf_pkg::CFG_GYRO_SCALE;
        cfg.data = '0;
        est_pitch = 0; est_bias = 0; est_flag = 1'b0;
        r_scale = 0; r_offset = 0; r_weight = 17'd62259; r_gain = 0;
        r_lower = 26843546; r_upper = 53687091; r_enable = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        rst_done = 1;

        // defaults after reset
        add_random(40);
        drain();

        // moderate gains, directed extremes then random
        write_all(32'd1700000, 16'sd100, 17'd62259, 32'd4000000, 32'd26843546,
                  32'd53687091, 1'b1);
        sample_q.push_back('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
        sample_q.push_back('{16'sh8000, 16'sh8000, 16'sh8000});
        sample_q.push_back('{16'sd0, 16'sd100, 16'sd0});       // zero accel vector
        sample_q.push_back('{16'sd5, 16'sd500, -16'sd4000});   // turned half, y >= 0
        sample_q.push_back('{-16'sd5, -16'sd500, -16'sd4000}); // turned half, y < 0
        sample_q.push_back('{16'sd0, 16'sd100, -16'sd4000});   // y exactly zero
        sample_q.push_back('{16'sd0, 16'sh7FFF, 16'sd0});
        sample_q.push_back('{16'sd0, 16'sh8000, 16'sd0});
        sample_q.push_back('{16'sd1, 16'sd8000, 16'sd8000});
        sample_q.push_back('{16'sd1, 16'sd8000, 16'sd8000});
        sample_q.push_back('{-16'sd1, -16'sd8000, 16'sd8000});
        sample_q.push_back('{-16'sd1, -16'sd8000, 16'sd8000});
        sample_q.push_back('{16'shFFFF, 16'sh0000, 16'sh0001});
        sample_q.push_back('{16'sh5555, 16'shAAAA, 16'sh5555});
        add_random(120);
        hold_cnt = 300;    // hold the output so the block backs up its input
        drain();

        // saturating gains, oversized weight, crossed limits
        write_all(32'hFFFFFFFF, 16'h8000, 17'h1FFFF, 32'hFFFFFFFF, 32'sd80000000,
                  32'sd10000000, 1'b1);
        sample_q.push_back('{16'sh7FFF, 16'sh7FFF, 16'sh8000});
        sample_q.push_back('{16'sh8000, 16'sh8000, 16'sh7FFF});
        sample_q.push_back('{16'sh8000, 16'sh8000, 16'sd0});   // zero after offset
        add_random(120);
        drain();

        // accel only, flag held, extreme limits
        write_all(32'd0, 16'h7FFF, 17'd0, 32'd65536, 32'h80000000, 32'h7FFFFFFF, 1'b0);
        sample_q.push_back('{16'sd0, 16'sh7FFF, 16'sd0});
        add_random(120);
        drain();

        // random settings, no idling to the end
        write_all($urandom_range(0, 8000000), 16'($urandom), 17'($urandom_range(0, 65536)),
                  $urandom_range(0, 40000000), $urandom_range(0, 50000000),
                  $urandom_range(20000000, 90000000), 1'b1);
        quiet = 1;
        add_random(130);
        drain();

        if (errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb: errors");
        $finish;
    end

endmodule

// ===== pitch_complementary_filter_top.f =====
hdl/pcf_pkg.sv
hdl/pcf_if.sv
hdl/pcf_ctrl.sv
hdl/pcf_dp.sv
hdl/pitch_complementary_filter_top.sv
verif/tb.sv
